// ----- hw/rtl/rsa_pkg.sv -----
package rsa_pkg;

  // field and datapath widths
  localparam int ADC_BITS   = 12;
  localparam int SUM_BITS   = 48;
  localparam int CNT_BITS   = 16;
  localparam int MV_BITS    = 16;
  localparam int SCALE_BITS = 10;
  localparam int ID_BITS    = 8;
  localparam int AVG_BITS   = 16;
  localparam int PROD_BITS  = ADC_BITS + MV_BITS + SCALE_BITS;
  // divisor width: wide enough for a reference code or a sample count
  localparam int DIV_BITS   = (ADC_BITS > CNT_BITS) ? ADC_BITS : CNT_BITS;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W  = ((2 * ADC_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((ID_BITS + AVG_BITS + 7) / 8) * 8;

  // configuration port
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic [2:0] REG_TICKS   = 3'd0;
  localparam logic [2:0] REG_SAMPLES = 3'd1;
  localparam logic [2:0] REG_REF_MV  = 3'd2;
  localparam logic [2:0] REG_SCALE   = 3'd3;
  localparam logic [2:0] REG_DEV_ID  = 3'd4;

  localparam logic [CNT_BITS-1:0]   TICKS_RST   = 16'd100;
  localparam logic [CNT_BITS-1:0]   SAMPLES_RST = 16'd600;
  localparam logic [MV_BITS-1:0]    REF_MV_RST  = 16'd2500;
  localparam logic [SCALE_BITS-1:0] SCALE_RST   = 10'd100;
  localparam logic [ID_BITS-1:0]    DEV_ID_RST  = 8'd0;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
  localparam logic [AVG_BITS-1:0] AVG_MAX = {AVG_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

endpackage

// ----- hw/rtl/rsa_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle:
// product = sensor * mv * scale, in two serial passes.
module rsa_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rsa_pkg::ADC_BITS-1:0]     sensor,
  input  logic [rsa_pkg::MV_BITS-1:0]      mv,
  input  logic [rsa_pkg::SCALE_BITS-1:0]   scale,
  output logic                             done,
  output logic [rsa_pkg::PROD_BITS-1:0]    product
);
  import rsa_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_A    = 2'd1;
  localparam logic [1:0] PH_B    = 2'd2;

  logic [1:0]            phase;
  logic [4:0]            cnt;
  logic [PROD_BITS-1:0]  acc;
  logic [PROD_BITS-1:0]  mcand;
  logic [ADC_BITS-1:0]   bits_a;
  logic [SCALE_BITS-1:0] bits_b;
  logic [PROD_BITS-1:0]  acc_next;
  logic                  bit_now;

  assign bit_now  = (phase == PH_A) ? bits_a[0] : bits_b[0];
  assign acc_next = bit_now ? acc + mcand : acc;
  assign product  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_A;
          end
        end
        PH_A: begin
          if (cnt == 5'(ADC_BITS - 1)) begin
            phase <= PH_B;
          end
        end
        PH_B: begin
          if (cnt == 5'(SCALE_BITS - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (start) begin
          acc    <= '0;
          mcand  <= PROD_BITS'(mv);
          bits_a <= sensor;
          bits_b <= scale;
          cnt    <= '0;
        end
      end
      PH_A: begin
        if (cnt == 5'(ADC_BITS - 1)) begin
          // first pass done: its product becomes the next multiplicand
          mcand <= acc_next;
          acc   <= '0;
          cnt   <= '0;
        end else begin
          acc    <= acc_next;
          mcand  <= {mcand[PROD_BITS-2:0], 1'b0};
          bits_a <= {1'b0, bits_a[ADC_BITS-1:1]};
          cnt    <= cnt + 5'd1;
        end
      end
      PH_B: begin
        acc    <= acc_next;
        mcand  <= {mcand[PROD_BITS-2:0], 1'b0};
        bits_b <= {1'b0, bits_b[SCALE_BITS-1:1]};
        cnt    <= cnt + 5'd1;
      end
      default: cnt <= '0;
    endcase
  end

endmodule

// ----- hw/rtl/rsa_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Shared by the per-sample scaling divide and the report average.
module rsa_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rsa_pkg::SUM_BITS-1:0]   dividend,
  input  logic [rsa_pkg::DIV_BITS-1:0]   divisor,
  output logic                           done,
  output logic [rsa_pkg::SUM_BITS-1:0]   quotient
);
  import rsa_pkg::*;

  localparam int CW = $clog2(SUM_BITS + 1);

  logic                busy;
  logic [CW-1:0]       cnt;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] dvs;
  logic [SUM_BITS-1:0] quo;
  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   diff;
  logic                ge;

  assign trial    = {rem, quo[SUM_BITS-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = ~diff[DIV_BITS];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(SUM_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        rem <= '0;
        dvs <= divisor;
        quo <= dividend;
        cnt <= '0;
      end
    end else begin
      rem <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      quo <= {quo[SUM_BITS-2:0], ge};
      cnt <= cnt + CW'(1);
    end
  end

endmodule

// ----- hw/rtl/ratiometric_sensor_averager_unit.sv -----
// A tick that is not a sample instant, or whose reference fails, is handled in ST_IDLE, a
// sample with a failed sensor read goes on to ST_CHECK, one with a good read runs the serial
// multiply (ST_MUL), then the bit-serial divider (ST_SDIV). A report with samples adds the
// average divide in the same divider (ST_RDIV) and sits in an output register; a further
// report waits until m_tready drains it. One item at a time.
// Reset (rst, synchronous): counters, sums and flags clear, registers take defaults.
module ratiometric_sensor_averager_unit (
  input  logic                              clk,
  input  logic                              rst,
  // input ticks
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rsa_pkg::S_TDATA_W-1:0]     s_tdata,  // ref_reading, sensor_reading
  input  logic [1:0]                        s_tuser,  // ref_ok, sensor_ok
  // reports
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rsa_pkg::M_TDATA_W-1:0]     m_tdata,  // report_id, average_value
  output logic [1:0]                        m_tuser,  // no_samples, saturated
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsa_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [rsa_pkg::DATA_BITS-1:0]     pwdata,
  output logic [rsa_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);
  import rsa_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a tick
  localparam logic [2:0] ST_MUL   = 3'd1;  // sensor * mV * scale
  localparam logic [2:0] ST_SDIV  = 3'd2;  // sample value = product / ref
  localparam logic [2:0] ST_CHECK = 3'd3;  // report due?
  localparam logic [2:0] ST_RDIV  = 3'd4;  // average = sum / count

  logic [2:0] state;

  // configuration registers
  logic [CNT_BITS-1:0]   ticks_per_sample;
  logic [CNT_BITS-1:0]   samples_per_report;
  logic [MV_BITS-1:0]    ref_millivolts;
  logic [SCALE_BITS-1:0] output_scale;
  logic [ID_BITS-1:0]    device_id;

  // running state
  logic [CNT_BITS-1:0]   tick_counter;
  logic [CNT_BITS-1:0]   sample_counter;
  logic [SUM_BITS-1:0]   value_sum;
  logic [CNT_BITS-1:0]   valid_count;
  logic                  sum_clipped;
  logic [ADC_BITS-1:0]   ref_hold;

  // output register
  logic [ID_BITS-1:0]    out_id;
  logic [AVG_BITS-1:0]   out_avg;
  logic                  out_empty;
  logic                  out_sat;

  // input fields
  logic                  ref_ok;
  logic                  sensor_ok;
  logic [ADC_BITS-1:0]   ref_reading;
  logic [ADC_BITS-1:0]   sensor_reading;

  assign ref_ok         = s_tuser[0];
  assign sensor_ok      = s_tuser[1];
  assign ref_reading    = s_tdata[ADC_BITS-1:0];
  assign sensor_reading = s_tdata[2*ADC_BITS-1:ADC_BITS];

  logic                  accept;
  logic [CNT_BITS-1:0]   tick_next;
  logic                  sample_now;
  logic                  ref_good;
  logic                  report_due;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid & s_tready;
  assign tick_next  = tick_counter + CNT_BITS'(1);
  assign sample_now = (tick_next >= ticks_per_sample);
  assign ref_good   = ref_ok & (ref_reading != '0);
  assign report_due = (sample_counter >= samples_per_report);

  // serial multiplier
  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_BITS-1:0] product;

  assign mul_start = accept & sample_now & ref_good & sensor_ok;

  rsa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .sensor  (sensor_reading),
    .mv      (ref_millivolts),
    .scale   (output_scale),
    .done    (mul_done),
    .product (product)
  );

  // shared divider: sample scaling started from ST_MUL, average started from ST_CHECK
  logic                div_start;
  logic                div_done;
  logic [SUM_BITS-1:0] div_num;
  logic [DIV_BITS-1:0] div_den;
  logic [SUM_BITS-1:0] quotient;

  assign div_start = (state == ST_MUL && mul_done) ||
                     (state == ST_CHECK && report_due && valid_count != '0 && !m_tvalid);
  assign div_num   = (state == ST_MUL) ? SUM_BITS'(product) : value_sum;
  assign div_den   = (state == ST_MUL) ? DIV_BITS'(ref_hold) : DIV_BITS'(valid_count);

  rsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quotient)
  );

  // accumulate with saturation
  logic [SUM_BITS:0] sum_wide;
  logic              avg_clip;

  assign sum_wide = {1'b0, value_sum} + {1'b0, quotient};
  assign avg_clip = (quotient[SUM_BITS-1:AVG_BITS] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_counter   <= '0;
      sample_counter <= '0;
      value_sum      <= '0;
      valid_count    <= '0;
      sum_clipped    <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!sample_now) begin
              tick_counter <= tick_next;
            end else begin
              tick_counter <= '0;
              if (!ref_good) begin
                // bad reference: drop the whole period
                sample_counter <= '0;
                value_sum      <= '0;
                valid_count    <= '0;
                sum_clipped    <= 1'b0;
              end else begin
                sample_counter <= sample_counter + CNT_BITS'(1);
                state          <= sensor_ok ? ST_MUL : ST_CHECK;
              end
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (div_done) begin
            if (sum_wide[SUM_BITS]) begin
              value_sum   <= SUM_MAX;
              sum_clipped <= 1'b1;
            end else begin
              value_sum <= sum_wide[SUM_BITS-1:0];
            end
            if (valid_count != CNT_MAX) begin
              valid_count <= valid_count + CNT_BITS'(1);
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!report_due) begin
            state <= ST_IDLE;
          end else if (!m_tvalid) begin
            // output slot free; otherwise hold here until it drains
            sample_counter <= '0;
            if (valid_count == '0) begin
              m_tvalid    <= 1'b1;
              value_sum   <= '0;
              sum_clipped <= 1'b0;
              state       <= ST_IDLE;
            end else begin
              state <= ST_RDIV;
            end
          end
        end
        ST_RDIV: begin
          if (div_done) begin
            m_tvalid    <= 1'b1;
            value_sum   <= '0;
            valid_count <= '0;
            sum_clipped <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (mul_start) begin
      ref_hold <= ref_reading;
    end
    if (state == ST_CHECK && report_due && !m_tvalid && valid_count == '0) begin
      out_id    <= device_id;
      out_avg   <= '0;
      out_empty <= 1'b1;
      out_sat   <= sum_clipped;
    end else if (state == ST_RDIV && div_done) begin
      out_id    <= device_id;
      out_avg   <= avg_clip ? AVG_MAX : quotient[AVG_BITS-1:0];
      out_empty <= 1'b0;
      out_sat   <= sum_clipped | avg_clip;
    end
  end

  assign m_tdata = M_TDATA_W'({out_avg, out_id});
  assign m_tuser = {out_sat, out_empty};

  // configuration port
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_sample   <= TICKS_RST;
      samples_per_report <= SAMPLES_RST;
      ref_millivolts     <= REF_MV_RST;
      output_scale       <= SCALE_RST;
      device_id          <= DEV_ID_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_TICKS:   ticks_per_sample   <= pwdata[CNT_BITS-1:0];
        REG_SAMPLES: samples_per_report <= pwdata[CNT_BITS-1:0];
        REG_REF_MV:  ref_millivolts     <= pwdata[MV_BITS-1:0];
        REG_SCALE:   output_scale       <= pwdata[SCALE_BITS-1:0];
        REG_DEV_ID:  device_id          <= pwdata[ID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TICKS:   prdata = DATA_BITS'(ticks_per_sample);
      REG_SAMPLES: prdata = DATA_BITS'(samples_per_report);
      REG_REF_MV:  prdata = DATA_BITS'(ref_millivolts);
      REG_SCALE:   prdata = DATA_BITS'(output_scale);
      REG_DEV_ID:  prdata = DATA_BITS'(device_id);
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- tb/sv/ratiometric_sensor_averager_unit_tb.sv -----
module ratiometric_sensor_averager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  // Worst-case time for one item: a multiply and sample divide plus a report divide.
  // Doubled for margin; used for the quiet time before register writes and at the end.
  localparam int LAT_CYCLES = 2 * ((4 + ADC_BITS + SCALE_BITS + SUM_BITS) + (SUM_BITS + 1));

  // One timer tick as seen on the input stream.
  typedef struct packed {
    logic                ref_ok;
    logic [ADC_BITS-1:0] ref_code;
    logic                sensor_ok;
    logic [ADC_BITS-1:0] sensor_code;
  } tick_t;

  // One averaged report as seen on the output stream.
  typedef struct packed {
    logic [ID_BITS-1:0]  dev_id;
    logic [AVG_BITS-1:0] avg;
    logic                empty;
    logic                clipped;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // ref_reading, sensor_reading
  logic [1:0]            s_tuser;   // ref_ok, sensor_ok
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // report_id, average_value
  logic [1:0]            m_tuser;   // no_samples, saturated
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_BITS-1:0]  paddr;
  logic [DATA_BITS-1:0]  pwdata;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  // Shadow copy of the register file.
  logic [CNT_BITS-1:0]   cfg_ticks;
  logic [CNT_BITS-1:0]   cfg_samples;
  logic [MV_BITS-1:0]    cfg_ref_mv;
  logic [SCALE_BITS-1:0] cfg_scale;
  logic [ID_BITS-1:0]    cfg_dev_id;

  // Shadow copy of the averaging state.
  logic [CNT_BITS-1:0]   tick_cnt;
  logic [CNT_BITS-1:0]   sample_cnt;
  logic [SUM_BITS-1:0]   acc_sum;
  logic [CNT_BITS-1:0]   good_count;
  logic                  acc_clipped;

  report_t               pending_reports[$];
  int                    errors       = 0;

  // Percent of cycles the sender idles and the receiver stalls in the current phase.
  int                    sender_idle_pct = 0;
  int                    recv_stall_pct  = 0;

  ratiometric_sensor_averager_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Receiver back-pressure, changed on the falling edge only.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor: one call per accepted tick, pushes the report it causes, if any.
  // ---------------------------------------------------------------------------
  task automatic clear_period();
    acc_sum     = '0;
    good_count  = '0;
    acc_clipped = 1'b0;
  endtask

  task automatic predict_tick(input tick_t t);
    logic [63:0] value;
    logic [63:0] mean;
    report_t     rep;
    tick_cnt = tick_cnt + 1'b1;  // 16-bit wrap
    // counter at or past its register triggers, so a zero register acts as one
    if (tick_cnt < cfg_ticks) return;
    tick_cnt   = '0;
    sample_cnt = sample_cnt + 1'b1;
    // bad or zero reference: drop the whole period, no report at this instant
    if (!t.ref_ok || t.ref_code == '0) begin
      clear_period();
      sample_cnt = '0;
      return;
    end
    // failed sensor read still counts as a sample instant
    if (t.sensor_ok) begin
      value = (64'(t.sensor_code) * 64'(cfg_ref_mv) * 64'(cfg_scale)) / 64'(t.ref_code);
      if (64'(acc_sum) > 64'(SUM_MAX) - value) begin
        acc_sum     = SUM_MAX;
        acc_clipped = 1'b1;
      end else begin
        acc_sum = SUM_BITS'(64'(acc_sum) + value);
      end
      if (good_count != CNT_MAX) good_count = good_count + 1'b1;
    end
    if (sample_cnt < cfg_samples) return;
    sample_cnt  = '0;
    rep.dev_id  = cfg_dev_id;
    rep.clipped = acc_clipped;
    if (good_count == '0) begin
      rep.avg   = '0;
      rep.empty = 1'b1;
    end else begin
      rep.empty = 1'b0;
      mean      = 64'(acc_sum) / 64'(good_count);
      if (mean > 64'(AVG_MAX)) begin
        rep.avg     = AVG_MAX;
        rep.clipped = 1'b1;
      end else begin
        rep.avg = AVG_BITS'(mean);
      end
    end
    pending_reports.push_back(rep);
    clear_period();
  endtask

  // ---------------------------------------------------------------------------
  // Output checker: every accepted report against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.dev_id  = m_tdata[ID_BITS-1:0];
      got.avg     = m_tdata[ID_BITS +: AVG_BITS];
      got.empty   = m_tuser[0];
      got.clipped = m_tuser[1];
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report id=%0d avg=%0d empty=%0b sat=%0b",
                 $time, got.dev_id, got.avg, got.empty, got.clipped);
      end else begin
        want = pending_reports.pop_front();
        if (got.dev_id !== want.dev_id || got.avg !== want.avg ||
            got.empty !== want.empty || got.clipped !== want.clipped) begin
          errors++;
          $write("%0t: report mismatch: expected id=%0d avg=%0d empty=%0b sat=%0b,",
                 $time, want.dev_id, want.avg, want.empty, want.clipped);
          $display(" got id=%0d avg=%0d empty=%0b sat=%0b",
                   got.dev_id, got.avg, got.empty, got.clipped);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. All drive tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input tick_t t);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'({t.sensor_code, t.ref_code});
    s_tuser  <= {t.sensor_ok, t.ref_ok};
    do @(posedge clk); while (!s_tready);
    predict_tick(t);
    @(negedge clk);
    // short geometric gaps plus the odd long one so idling lands in every divider phase
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (sender_idle_pct > 0 && $urandom_range(19) == 0) gap += $urandom_range(1, 150);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic tick_t make_tick(input int rok, input int rcode,
                                      input int sok, input int scode);
    tick_t t;
    t.ref_ok      = 1'(rok);
    t.ref_code    = ADC_BITS'(rcode);
    t.sensor_ok   = 1'(sok);
    t.sensor_code = ADC_BITS'(scode);
    return t;
  endfunction

  // Mostly good ticks with random readings; the rest is noise that mostly hits the clear path.
  function automatic tick_t rand_tick();
    tick_t t;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 88) begin
      t.ref_ok   = 1'b1;
      t.ref_code = ADC_BITS'($urandom_range(1, (1 << ADC_BITS) - 1));
    end else begin
      t.ref_ok   = 1'($urandom_range(1));
      t.ref_code = $urandom_range(1) ? '0 : ADC_BITS'($urandom);
    end
    t.sensor_ok = ($urandom_range(99) < 85);
    case ($urandom_range(9))
      0:       t.sensor_code = '0;
      1:       t.sensor_code = '1;
      default: t.sensor_code = ADC_BITS'($urandom);
    endcase
    return t;
  endfunction

  // Hold the sender off until every report is out and the divider has gone quiet.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (LAT_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [DATA_BITS-1:0] wdata,
                            output logic [DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [DATA_BITS-1:0] rdata;
    logic [DATA_BITS-1:0] want;
    logic [DATA_BITS-1:0] mask;
    case (idx)
      REG_TICKS:   begin want = DATA_BITS'(cfg_ticks);   mask = DATA_BITS'(CNT_MAX); end
      REG_SAMPLES: begin want = DATA_BITS'(cfg_samples); mask = DATA_BITS'(CNT_MAX); end
      REG_REF_MV:  begin want = DATA_BITS'(cfg_ref_mv);  mask = DATA_BITS'({MV_BITS{1'b1}}); end
      REG_SCALE:   begin want = DATA_BITS'(cfg_scale);   mask = DATA_BITS'({SCALE_BITS{1'b1}}); end
      default:     begin want = DATA_BITS'(cfg_dev_id);  mask = DATA_BITS'({ID_BITS{1'b1}}); end
    endcase
    apb_access(1'b0, idx, '0, rdata);
    if ((rdata & mask) !== want) begin
      errors++;
      $display("%0t: register %0d readback: expected %0d, got %0d",
               $time, idx, want, rdata & mask);
    end
  endtask

  // Caller makes sure the block is idle first.
  task automatic write_reg(input logic [2:0] idx, input int value);
    logic [DATA_BITS-1:0] unused;
    apb_access(1'b1, idx, DATA_BITS'(value), unused);
    case (idx)
      REG_TICKS:   cfg_ticks   = CNT_BITS'(value);
      REG_SAMPLES: cfg_samples = CNT_BITS'(value);
      REG_REF_MV:  cfg_ref_mv  = MV_BITS'(value);
      REG_SCALE:   cfg_scale   = SCALE_BITS'(value);
      default:     cfg_dev_id  = ID_BITS'(value);
    endcase
    check_reg(idx);
  endtask

  task automatic write_all(input int ticks, input int samples, input int ref_mv,
                           input int scale, input int dev_id);
    write_reg(REG_TICKS, ticks);
    write_reg(REG_SAMPLES, samples);
    write_reg(REG_REF_MV, ref_mv);
    write_reg(REG_SCALE, scale);
    write_reg(REG_DEV_ID, dev_id);
  endtask

  // Short periods keep reports frequent; extremes of the value registers come up often.
  task automatic random_config();
    int ticks;
    int samples;
    int ref_mv;
    int scale;
    ticks   = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4);
    samples = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
    case ($urandom_range(3))
      0:       ref_mv = 1;
      1:       ref_mv = 65535;
      default: ref_mv = $urandom_range(1, 65535);
    endcase
    case ($urandom_range(3))
      0:       scale = 1;
      1:       scale = 1023;
      default: scale = $urandom_range(1, 1023);
    endcase
    write_all(ticks, samples, ref_mv, scale, $urandom_range(255));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers come out of reset at their defaults; a hundred-odd ticks with the
  // default period give one sample instant and no report.
  task automatic test_defaults();
    check_reg(REG_TICKS);
    check_reg(REG_SAMPLES);
    check_reg(REG_REF_MV);
    check_reg(REG_SCALE);
    check_reg(REG_DEV_ID);
    repeat (120) send_tick(rand_tick());
    wait_idle();
  endtask

  // Field extremes, saturated average, both reference failures, sensor failure
  // and an empty period.
  task automatic test_extremes();
    write_all(1, 2, 65535, 1023, 255);
    send_tick(make_tick(1, 4095, 1, 4095));
    send_tick(make_tick(1, 4095, 1, 0));
    send_tick(make_tick(1, 1, 1, 4095));      // average clips to 16 bits
    send_tick(make_tick(1, 1, 1, 4095));
    send_tick(make_tick(1, 4095, 1, 1234));
    send_tick(make_tick(0, 4095, 1, 4095));   // reference failed: period dropped
    send_tick(make_tick(1, 2000, 1, 3000));
    send_tick(make_tick(1, 0, 1, 4095));      // zero reference code: period dropped
    send_tick(make_tick(1, 2048, 0, 4095));   // sensor failed twice: empty report
    send_tick(make_tick(1, 2048, 0, 4095));
    send_tick(make_tick(1, 2048, 1, 100));
    send_tick(make_tick(1, 2048, 0, 7));
    wait_idle();
    write_all(1, 1, 1, 1, 0);
    send_tick(make_tick(1, 4095, 1, 4095));
    send_tick(make_tick(1, 4095, 1, 1));      // floor down to zero
    send_tick(make_tick(1, 1, 0, 0));
    send_tick(make_tick(0, 0, 0, 0));
    wait_idle();
  endtask

  // Zero period registers behave like one.
  task automatic test_zero_periods();
    write_all(0, 0, 3300, 512, 8'hA5);
    repeat (6) send_tick(rand_tick());
    wait_idle();
  endtask

  // Lowering a period register under the running count fires on the next event.
  task automatic test_lowered_periods();
    write_all(65535, 65535, 2500, 100, 8'h5A);
    repeat (5) send_tick(make_tick(1, 3000, 1, 1500));
    wait_idle();
    write_reg(REG_TICKS, 1);
    repeat (4) send_tick(make_tick(1, 3000, 1, 1500));
    wait_idle();
    write_reg(REG_SAMPLES, 2);
    repeat (3) send_tick(make_tick(1, 3000, 1, 2500));
    wait_idle();
  endtask

  // Largest sample value into one long period: the accumulator must clip.
  task automatic test_sum_overflow();
    write_all(1, 1030, 65535, 1023, 8'h3C);
    repeat (1030) send_tick(make_tick(1, 1, 1, 4095));
    wait_idle();
  endtask

  // Random ticks under one idling pattern, new settings every so often.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int sent;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    sent            = 0;
    while (sent < n_items) begin
      if (sent % 40 == 0) begin
        wait_idle();
        random_config();
      end
      send_tick(rand_tick());
      sent++;
      // now and then drain completely in the middle of a setting
      if ($urandom_range(99) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;

    cfg_ticks   = TICKS_RST;
    cfg_samples = SAMPLES_RST;
    cfg_ref_mv  = REF_MV_RST;
    cfg_scale   = SCALE_RST;
    cfg_dev_id  = DEV_ID_RST;
    tick_cnt    = '0;
    sample_cnt  = '0;
    clear_period();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_defaults();
    test_extremes();
    test_zero_periods();
    test_lowered_periods();
    test_sum_overflow();
    test_random_traffic(0, 0, 80);
    test_random_traffic(61, 0, 80);
    test_random_traffic(0, 61, 80);
    test_random_traffic(7, 7, 80);

    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("%0t: timeout, %0d reports still expected", $time, pending_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rsa_pkg.sv
hw/rtl/rsa_mul.sv
hw/rtl/rsa_div.sv
hw/rtl/ratiometric_sensor_averager_unit.sv
tb/sv/ratiometric_sensor_averager_unit_tb.sv
